// ----- rtl/pmfb_pkg.sv -----
// Shared types and constants for the page-mode framebuffer fill block.
// No dependencies; every other file imports this package.
`default_nettype none

package pmfb_pkg;

   localparam int ROWS_DEFAULT  = 16;
   localparam int COLS_DEFAULT  = 64;
   localparam int QUEUE_DEFAULT = 2;
   localparam int PAGE_ROWS     = 8;
   localparam int WORD_BYTES    = 8;

   localparam logic [1:0] OP_PAINT  = 2'd0;
   localparam logic [1:0] OP_ERASE  = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;
   localparam logic [1:0] OP_ENCODE = 2'd3;

   typedef struct packed {
      logic [1:0] opcode;
      logic [5:0] left_column;
      logic [3:0] top_row;
      logic [6:0] rect_width;
      logic [4:0] rect_height;
   } req_type;

   typedef struct packed {
      logic [63:0] page_bytes;
      logic [3:0]  word_index;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [3:0] row_first;
      logic [6:0] row_end;
      logic [5:0] col_first;
      logic [7:0] col_end;
   } cmd_type;

   typedef struct packed {
      logic queue_full;
      logic store_init;
   } hold_type;

endpackage

`default_nettype wire

// ----- rtl/pmfb_front.sv -----
// Front end: accepts commands, clips rectangles and queues the work.
// Depends on pmfb_pkg.
`default_nettype none

module pmfb_front #(
   parameter int ROWS = pmfb_pkg::ROWS_DEFAULT,
   parameter int COLS = pmfb_pkg::COLS_DEFAULT
) (
   input  logic              start,
   input  pmfb_pkg::req_type req_data,
   input  pmfb_pkg::hold_type hold,
   output logic              busy,
   output logic              push,
   output pmfb_pkg::cmd_type push_data
);
   import pmfb_pkg::*;

   localparam logic [6:0] ROW_LIMIT = 7'(ROWS);
   localparam logic [7:0] COL_LIMIT = 8'(COLS);

   logic [6:0] row_sum;
   logic [7:0] col_sum;
   logic       is_rect;
   logic       empty_rect;

   assign row_sum = 7'(req_data.top_row) + 7'(req_data.rect_height);
   assign col_sum = 8'(req_data.left_column) + 8'(req_data.rect_width);

   assign is_rect = (req_data.opcode == OP_PAINT) || (req_data.opcode == OP_ERASE);
   assign empty_rect = (7'(req_data.top_row) >= ROW_LIMIT) || (req_data.rect_height == '0) ||
                       (req_data.rect_width == '0) || (8'(req_data.left_column) >= COL_LIMIT);

   assign busy = hold.queue_full | hold.store_init;
   // drop rectangles that clip away entirely
   assign push = start & ~busy & ~(is_rect & empty_rect);

   always_comb begin
      push_data.opcode    = req_data.opcode;
      push_data.row_first = req_data.top_row;
      push_data.row_end   = (row_sum > ROW_LIMIT) ? ROW_LIMIT : row_sum;
      push_data.col_first = req_data.left_column;
      push_data.col_end   = (col_sum > COL_LIMIT) ? COL_LIMIT : col_sum;
   end

endmodule

`default_nettype wire

// ----- rtl/pmfb_cmdq.sv -----
// Short command queue between the front end and the store sequencer.
// Depends on pmfb_pkg.
`default_nettype none

module pmfb_cmdq #(
   parameter int DEPTH = pmfb_pkg::QUEUE_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pmfb_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output pmfb_pkg::cmd_type pop_data,
   output logic              empty
);
   import pmfb_pkg::*;

   localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNW = $clog2(DEPTH + 1);

   cmd_type        slot_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNW-1:0] count_ff, count_in;

   assign full     = (count_ff == CNW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      count_in = count_ff + CNW'(push) - CNW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/pmfb_back.sv -----
// Back end: pixel row store, rectangle read-modify-write, clear sweep and
// page readout packing. Depends on pmfb_pkg.
`default_nettype none

module pmfb_back #(
   parameter int ROWS = pmfb_pkg::ROWS_DEFAULT,
   parameter int COLS = pmfb_pkg::COLS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  pmfb_pkg::cmd_type q_data,
   output logic              q_pop,
   output logic              store_init,
   output logic              rsp_valid,
   output pmfb_pkg::rsp_type rsp_data
);
   import pmfb_pkg::*;

   localparam int RW = $clog2(ROWS);
   localparam int RB = RW + 2;
   localparam int CW = $clog2(COLS + 1);

   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_FILL  = 3'd2;
   localparam logic [2:0] ST_CLEAR = 3'd3;
   localparam logic [2:0] ST_LOAD  = 3'd4;
   localparam logic [2:0] ST_WAIT  = 3'd5;
   localparam logic [2:0] ST_PACK  = 3'd6;

   logic [COLS-1:0] pixel_rows_ff [ROWS];
   logic [COLS-1:0] rd_data_ff;
   logic            rd_en, wr_en;
   logic [RW-1:0]   rd_addr, wr_addr;
   logic [COLS-1:0] wr_data;

   logic [2:0]      state_ff, state_in;
   cmd_type         cmd_ff, cmd_in;
   logic [RW-1:0]   cnt_ff, cnt_in;
   logic [RW-1:0]   wr_row_ff, wr_row_in;
   logic [RW-1:0]   base_ff, base_in;
   logic [2:0]      lcnt_ff, lcnt_in;
   logic [2:0]      fill_ff, fill_in;
   logic            fill_pend_ff, fill_pend_in;
   logic            load_pend_ff, load_pend_in;
   logic [COLS-1:0] page_ff [PAGE_ROWS];
   logic [COLS-1:0] page_in [PAGE_ROWS];
   logic [CW-1:0]   rem_ff, rem_in;
   logic [63:0]     acc_ff, acc_in;
   logic [3:0]      widx_ff, widx_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;

   logic [COLS-1:0] col_mask;
   logic [3:0]      avail, take, fill_sum;
   logic [63:0]     cand, keep, placed, acc_sum;
   logic [CW-1:0]   rem_sub;
   logic            page_done, last_page, stream_end;

   assign store_init = (state_ff == ST_INIT);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      for (int c = 0; c < COLS; c++) begin
         col_mask[c] = (8'(c) >= 8'(cmd_ff.col_first)) && (8'(c) < cmd_ff.col_end);
      end
   end

   always_comb begin
      rd_en   = (state_ff == ST_FILL) || (state_ff == ST_LOAD);
      rd_addr = (state_ff == ST_LOAD) ? base_ff + RW'(lcnt_ff) : cnt_ff;
      wr_en   = fill_pend_ff || (state_ff == ST_INIT) || (state_ff == ST_CLEAR);
      if (fill_pend_ff) begin
         wr_addr = wr_row_ff;
         wr_data = (cmd_ff.opcode == OP_PAINT) ? (rd_data_ff | col_mask)
                                               : (rd_data_ff & ~col_mask);
      end else begin
         wr_addr = cnt_ff;
         wr_data = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pixel_rows_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= pixel_rows_ff[rd_addr];
      end
   end

   always_comb begin
      avail = 4'(WORD_BYTES) - {1'b0, fill_ff};
      take  = (rem_ff >= CW'(avail)) ? avail : 4'(rem_ff);
      for (int b = 0; b < WORD_BYTES; b++) begin
         for (int i = 0; i < PAGE_ROWS; i++) begin
            cand[8*b+i] = ~page_ff[i][b];
         end
         keep[8*b +: 8] = (4'(b) < take) ? 8'hFF : 8'h00;
      end
      placed     = (cand & keep) << {fill_ff, 3'b000};
      acc_sum    = acc_ff | placed;
      fill_sum   = {1'b0, fill_ff} + take;
      rem_sub    = rem_ff - CW'(take);
      page_done  = (rem_sub == '0);
      last_page  = (RB'(base_ff) + RB'(2 * PAGE_ROWS)) > RB'(ROWS);
      stream_end = page_done && last_page;
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      cnt_in       = cnt_ff;
      wr_row_in    = wr_row_ff;
      base_in      = base_ff;
      lcnt_in      = lcnt_ff;
      fill_in      = fill_ff;
      fill_pend_in = 1'b0;
      load_pend_in = 1'b0;
      rem_in       = rem_ff;
      acc_in       = acc_ff;
      widx_in      = widx_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      for (int i = 0; i < PAGE_ROWS; i++) begin
         page_in[i] = page_ff[i];
      end

      // shift each loaded row into the page line
      if (load_pend_ff) begin
         for (int i = 0; i < PAGE_ROWS - 1; i++) begin
            page_in[i] = page_ff[i+1];
         end
         page_in[PAGE_ROWS-1] = rd_data_ff;
      end

      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            if (cnt_ff == RW'(ROWS - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + RW'(1);
            end
         end
         ST_IDLE: begin
            q_pop = !q_empty;
            if (!q_empty) begin
               cmd_in = q_data;
               case (q_data.opcode)
                  OP_PAINT, OP_ERASE: begin
                     cnt_in   = RW'(q_data.row_first);
                     state_in = ST_FILL;
                  end
                  OP_CLEAR: begin
                     cnt_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  OP_ENCODE: begin
                     base_in  = '0;
                     lcnt_in  = '0;
                     acc_in   = '0;
                     fill_in  = '0;
                     widx_in  = '0;
                     state_in = ST_LOAD;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_FILL: begin
            fill_pend_in = 1'b1;
            wr_row_in    = cnt_ff;
            if (7'(cnt_ff) + 7'd1 == cmd_ff.row_end) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + RW'(1);
            end
         end
         ST_LOAD: begin
            load_pend_in = 1'b1;
            if (lcnt_ff == 3'(PAGE_ROWS - 1)) begin
               state_in = ST_WAIT;
            end else begin
               lcnt_in = lcnt_ff + 3'd1;
            end
         end
         ST_WAIT: begin
            rem_in   = CW'(COLS);
            state_in = ST_PACK;
         end
         ST_PACK: begin
            for (int i = 0; i < PAGE_ROWS; i++) begin
               page_in[i] = page_ff[i] >> take;
            end
            rem_in = rem_sub;
            if ((fill_sum == 4'(WORD_BYTES)) || stream_end) begin
               rsp_valid_in       = 1'b1;
               rsp_in.page_bytes  = acc_sum;
               rsp_in.word_index  = widx_ff;
               rsp_in.last        = stream_end;
               widx_in            = widx_ff + 4'd1;
               acc_in             = '0;
               fill_in            = '0;
            end else begin
               acc_in  = acc_sum;
               fill_in = fill_sum[2:0];
            end
            if (page_done) begin
               if (last_page) begin
                  state_in = ST_IDLE;
               end else begin
                  base_in  = base_ff + RW'(PAGE_ROWS);
                  lcnt_in  = '0;
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         base_ff      <= '0;
         lcnt_ff      <= '0;
         fill_ff      <= '0;
         rem_ff       <= '0;
         widx_ff      <= '0;
         fill_pend_ff <= 1'b0;
         load_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         base_ff      <= base_in;
         lcnt_ff      <= lcnt_in;
         fill_ff      <= fill_in;
         rem_ff       <= rem_in;
         widx_ff      <= widx_in;
         fill_pend_ff <= fill_pend_in;
         load_pend_ff <= load_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      wr_row_ff <= wr_row_in;
      acc_ff    <= acc_in;
      rsp_ff    <= rsp_in;
      for (int i = 0; i < PAGE_ROWS; i++) begin
         page_ff[i] <= page_in[i];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/page_mode_framebuffer_fill.sv -----
// Top level of the page-mode framebuffer fill block.
// Depends on pmfb_pkg, pmfb_front, pmfb_cmdq and pmfb_back.
//
//   channel   ports                     transfer
//   command   start, busy, req_data     taken when start high and busy low
//   result    rsp_valid, rsp_data       one-cycle strobe, cannot be held off
//
// Paint and erase visit each clipped row in turn; clear sweeps every row to blank.
// Encode loads each page of eight rows from the single read port and then packs
// its columns into words, one result per packed word.
// After reset the store is swept to blank with busy high.
// Busy also rises while the command queue is full; results never stall.
`default_nettype none

module page_mode_framebuffer_fill #(
   parameter int ROWS        = pmfb_pkg::ROWS_DEFAULT,
   parameter int COLS        = pmfb_pkg::COLS_DEFAULT,
   parameter int QUEUE_DEPTH = pmfb_pkg::QUEUE_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  pmfb_pkg::req_type req_data,
   output logic              busy,
   output logic              rsp_valid,
   output pmfb_pkg::rsp_type rsp_data
);
   import pmfb_pkg::*;

   hold_type hold;
   logic     push, pop, q_full, q_empty, store_init;
   cmd_type  push_data, pop_data;

   assign hold.queue_full = q_full;
   assign hold.store_init = store_init;

   pmfb_front #(
      .ROWS(ROWS),
      .COLS(COLS)
   ) u_front (
      .start    (start),
      .req_data (req_data),
      .hold     (hold),
      .busy     (busy),
      .push     (push),
      .push_data(push_data)
   );

   pmfb_cmdq #(
      .DEPTH(QUEUE_DEPTH)
   ) u_cmdq (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .full     (q_full),
      .pop      (pop),
      .pop_data (pop_data),
      .empty    (q_empty)
   );

   pmfb_back #(
      .ROWS(ROWS),
      .COLS(COLS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (pop_data),
      .q_pop     (pop),
      .store_init(store_init),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- rtl/pmfb_check.sv -----
// Port-level checker for the page-mode framebuffer fill block, bound to the top.
// Depends on pmfb_pkg.
`default_nettype none

module pmfb_check (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input pmfb_pkg::req_type req_data,
   input logic              busy,
   input logic              rsp_valid,
   input pmfb_pkg::rsp_type rsp_data
);
   import pmfb_pkg::*;

   // store sweep holds commands off right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> (busy && !rsp_valid))
      else $error("busy low or result during reset sweep");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(rsp_valid)) |->
         (rsp_data.word_index == 4'($past(rsp_data.word_index) + 4'd1)))
      else $error("word index did not advance");

   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last) |=> !rsp_valid)
      else $error("result right after last word");

   a_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({busy, rsp_valid}))
      else $error("busy or result strobe unknown");

endmodule

bind page_mode_framebuffer_fill pmfb_check u_check (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .req_data (req_data),
   .busy     (busy),
   .rsp_valid(rsp_valid),
   .rsp_data (rsp_data)
);

`default_nettype wire
